@@ design/mpsm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mpsm_pkg;

	// width of every port field
	localparam int unsigned FIELD_WIDTH = 32;

	// modulus after reset
	localparam logic [FIELD_WIDTH-1:0] MODULUS_RESET = 32'd10007;

	// sequencer states
	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_REDUCE = 5'b00010,
		S_DBL    = 5'b00100,
		S_ADD    = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

endpackage

`default_nettype wire

@@ design/modular_power_square_multiply.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel | signals                                    | direction
// --------+--------------------------------------------+----------
// in      | in_valid, in_ready, base_value, exponent   | to block
// out     | out_valid, out_ready, power_residue        | from block
// cfg     | cfg_valid, cfg_ready, modulus              | to block
//
// one shared modular adder ((x + y + c) mod m: one add, one compare, one subtract) does
// all the work, one step a cycle. base reduction comes first, then each exponent bit takes
// a squaring plus, for a set bit, a base multiply.
// in_ready is high only in idle; the finished word waits in an output register, so a
// stalled out channel holds the sequencer in its final state. reset is async, active low;
// the modulus resets to 10007 and cfg writes are taken in any cycle.

module modular_power_square_multiply
	import mpsm_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire [FIELD_WIDTH-1:0]  base_value,
	input  wire [FIELD_WIDTH-1:0]  exponent,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic [FIELD_WIDTH-1:0] power_residue,
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire [FIELD_WIDTH-1:0]  modulus
);

	localparam int unsigned CW = $clog2(DATA_WIDTH);
	localparam logic [CW-1:0] LAST = CW'(DATA_WIDTH - 1);

	state_t state_q;
	logic [FIELD_WIDTH-1:0] modulus_q;
	logic [DATA_WIDTH-1:0]  m_q, b_q, e_q, acc_q, prod_q;
	logic [CW-1:0]          cnt_q, ecnt_q;
	logic                   sq_q;
	logic                   out_valid_q;
	logic [FIELD_WIDTH-1:0] out_q;

	logic [DATA_WIDTH-1:0] mod_w, base_w, exp_w;
	logic [DATA_WIDTH-1:0] ua_w, ub_w, unit_w;
	logic                  uc_w;
	logic [DATA_WIDTH:0]   sum_w;
	logic                  in_acc_w, out_free_w;

	// datapath width view of the fields
	assign mod_w  = DATA_WIDTH'(modulus_q);
	assign base_w = DATA_WIDTH'(base_value);
	assign exp_w  = DATA_WIDTH'(exponent);

	assign in_ready      = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign out_valid     = out_valid_q;
	assign power_residue = out_q;
	assign in_acc_w      = in_valid && in_ready;
	assign out_free_w    = !out_valid_q || out_ready;

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
		end else if (cfg_valid) begin
			modulus_q <= modulus;
		end
	end

	// shared unit operands
	always_comb begin
		ua_w = prod_q;
		ub_w = prod_q;
		uc_w = 1'b0;
		unique case (state_q)
			S_REDUCE: uc_w = b_q[cnt_q];
			S_ADD:    ub_w = sq_q ? acc_q : b_q;
			default: begin
			end
		endcase
	end

	// shared modular adder, operands below m so one subtract suffices
	assign sum_w  = {1'b0, ua_w} + {1'b0, ub_w} + {{DATA_WIDTH{1'b0}}, uc_w};
	assign unit_w = (sum_w >= {1'b0, m_q}) ? DATA_WIDTH'(sum_w - {1'b0, m_q})
		: sum_w[DATA_WIDTH-1:0];

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			ecnt_q      <= '0;
			sq_q        <= 1'b1;
		end else begin
			// output word flag: loaded out of the final state, cleared when taken
			priority if (state_q == S_DONE && out_free_w) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc_w) begin
						cnt_q   <= LAST;
						state_q <= (mod_w == '0) ? S_DONE : S_REDUCE;
					end
				end
				S_REDUCE: begin
					if (cnt_q == '0) begin
						cnt_q   <= LAST;
						ecnt_q  <= LAST;
						sq_q    <= 1'b1;
						state_q <= S_DBL;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				S_DBL, S_ADD: begin
					priority if (state_q == S_DBL && acc_q[cnt_q]) begin
						state_q <= S_ADD;
					end else if (cnt_q != '0) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= S_DBL;
					end else begin
						// one modular product finished
						cnt_q <= LAST;
						priority if (sq_q && e_q[DATA_WIDTH-1]) begin
							sq_q    <= 1'b0;
							state_q <= S_DBL;
						end else if (ecnt_q == '0) begin
							sq_q    <= 1'b1;
							state_q <= S_DONE;
						end else begin
							sq_q    <= 1'b1;
							ecnt_q  <= ecnt_q - CW'(1);
							state_q <= S_DBL;
						end
					end
				end
				S_DONE: begin
					if (out_free_w) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc_w) begin
					m_q    <= mod_w;
					b_q    <= base_w;
					e_q    <= exp_w;
					prod_q <= '0;
					acc_q  <= '0;
				end
			end
			S_REDUCE: begin
				if (cnt_q == '0) begin
					b_q    <= unit_w;
					acc_q  <= (m_q == DATA_WIDTH'(1)) ? '0 : DATA_WIDTH'(1);
					prod_q <= '0;
				end else begin
					prod_q <= unit_w;
				end
			end
			S_DBL, S_ADD: begin
				if ((state_q == S_DBL && acc_q[cnt_q]) || cnt_q != '0) begin
					prod_q <= unit_w;
				end else begin
					acc_q  <= unit_w;
					prod_q <= '0;
					if (!(sq_q && e_q[DATA_WIDTH-1])) begin
						e_q <= e_q << 1;
					end
				end
			end
			S_DONE: begin
				if (out_free_w) begin
					out_q <= FIELD_WIDTH'(acc_q);
				end
			end
			default: begin
			end
		endcase
	end

	// accumulators stay reduced while the products run
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DBL || state_q == S_ADD) |-> (acc_q < m_q) && (prod_q < m_q))
		else $error("accumulator not reduced below modulus");

	// zero modulus goes straight to a zero result
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc_w && mod_w == '0) |=> (state_q == S_DONE) && (acc_q == '0))
		else $error("zero modulus not short-cut");

	// a result appears only out of the final state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result word raised outside final state");

endmodule

`default_nettype wire
